// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority task queue package
// Transaction types, status and operation codes shared by the queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // operation codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                func;
      logic [HANDLE_W-1:0] task_handle;
      logic [PRIO_W-1:0]   task_prio;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] head_handle;
      logic [PRIO_W-1:0]   head_prio;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // contents of one queue cell
   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                push;
      logic                pop;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } cell_ctrl_type;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority task queue cell
// One slot of the sorted shift queue: holds, loads, or shifts per command.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type     left_entry,
   input  logic                   left_after,
   input  spq_pkg::entry_type     right_entry,
   output logic                   after,
   output spq_pkg::entry_type     entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new task belongs behind this slot (ties keep arrival order)
   assign after = entry_ff.valid && (entry_ff.prio <= ctrl.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!after) begin
            if (left_after) begin
               entry_in.valid  = 1'b1;
               entry_in.handle = ctrl.handle;
               entry_in.prio   = ctrl.prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.handle <= entry_in.handle;
      entry_ff.prio   <= entry_in.prio;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

// File: sv/stable_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// Stable priority task queue
// Bounded sorted queue of task handles built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: a push (handle and priority) or a pop.
//   rsp_* returns one transaction per request: status, removed handle and
//   priority on a good pop, and the occupancy after the operation.
//   Lower priority values leave first; equal priorities leave in push order.
//   A push into a full queue is refused with a full status; a pop on an empty
//   queue returns an empty status.
//   The response is registered and shows in the cycle after accept.
//   Throughput: one request per cycle while responses are taken. Every cell
//   compares its priority with the incoming one and loads, holds or shifts in
//   the same cycle, so the whole sorted row is updated together.
//   When the receiver stalls, the response register holds and req_ready
//   drops until it is taken; a request is accepted in the same cycle the
//   waiting response leaves.
//   Reset clears all valid bits and the count; the queue comes up empty and
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_task_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   spq_pkg::entry_type     ent [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] after;
   logic [QUEUE_DEPTH-1:0] valid_vec;
   spq_pkg::cell_ctrl_type ctrl;

   logic             rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type rsp_ff, rsp_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic accept, is_pop, full, empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_pop    = (req_data.func == spq_pkg::FUNC_POP);
   assign full      = ent[QUEUE_DEPTH-1].valid;
   assign empty     = !ent[0].valid;

   always_comb begin
      ctrl.push   = accept && !is_pop && !full;
      ctrl.pop    = accept && is_pop && !empty;
      ctrl.handle = req_data.task_handle;
      ctrl.prio   = req_data.task_prio;
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;
         logic               left_after;

         if (gi == 0) begin : g_first
            assign left_entry = '0;
            assign left_after = 1'b1;
         end else begin : g_mid
            assign left_entry = ent[gi-1];
            assign left_after = after[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = ent[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .after       (after[gi]),
            .entry       (ent[gi])
         );

         assign valid_vec[gi] = ent[gi].valid;
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = spq_pkg::ST_OK;
         rsp_in.head_handle = '0;
         rsp_in.head_prio   = '0;
         rsp_in.occupancy   = spq_pkg::OCC_W'({{spq_pkg::OCC_W{1'b0}}, count_in});
         if (is_pop) begin
            if (empty) begin
               rsp_in.status = spq_pkg::ST_EMPTY;
            end else begin
               rsp_in.head_handle = ent[0].handle;
               rsp_in.head_prio   = ent[0].prio;
            end
         end else if (full) begin
            rsp_in.status = spq_pkg::ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ordering check over neighboring valid cells
   logic [QUEUE_DEPTH-2:0] order_ok;
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
         order_ok[k] = !ent[k+1].valid || (ent[k].prio <= ent[k+1].prio);
      end
   end

   logic [QUEUE_DEPTH:0] valid_plus;
   assign valid_plus = {1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1};

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_vec)))
      else $error("count does not match number of valid cells");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot(valid_plus))
      else $error("valid cells are not a contiguous prefix");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("queue entries out of priority order");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule
